// ----- hw/rtl/tep_pkg.sv -----
// tep_pkg: shared types and constants of the tile map edge probe
// no dependencies; used by tep_ctrl, tep_datapath and tilemap_edge_probe

package tep_pkg;

   // default map geometry
   localparam int MAP_COLS_DEF    = 128;
   localparam int MAP_ROWS_DEF    = 32;
   localparam int TILE_PIXELS_DEF = 16;

   // field widths of the request word
   localparam int IDX_W  = 12;
   localparam int VAL_W  = 8;
   localparam int POSX_W = 11;
   localparam int POSY_W = 9;
   localparam int OFS8_W = 8;
   localparam int SIDE_W = 2;
   localparam int CODE_W = 2;

   // pixel coordinates reach 2558 at most, tiles 639 at most (tiles of 4 pixels)
   localparam int COORD_W = 12;
   localparam int TILE_W  = 10;
   // fixed-point shift of the reciprocal used for pixel to tile conversion
   localparam int DIV_SHIFT = 20;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PROBE = 1'b1;

   // side codes
   localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch the request word
      logic clear_step;  // write zero at the clear counter and advance it
      logic tile_write;  // store the captured tile flag
      logic calc_coord;  // edge coordinates from the box
      logic calc_tile;   // pixel to tile conversion
      logic calc_term;   // address terms and bounds flags
      logic step;        // advance to the next sample
      logic respond;     // latch the hit code of the current sample
   } tep_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_probe;    // captured word is a probe
      logic clear_done;  // clear counter at its last entry
      logic hit;         // current sample found a solid tile
      logic last;        // current sample is the last one on the edge
   } tep_status_type;

endpackage

// ----- hw/rtl/tep_ram.sv -----
// tep_ram: generic ram, one write port and two registered read ports
// no dependencies

module tep_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hw/rtl/tep_ctrl.sv -----
// tep_ctrl: sequencing state machine of the edge probe
// depends on tep_pkg

module tep_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output tep_pkg::tep_cmd_type    cmd,
   input  tep_pkg::tep_status_type status
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_WRITE  = 8'b0000_0100,
      ST_COORD  = 8'b0000_1000,
      ST_TILE   = 8'b0001_0000,
      ST_TERM   = 8'b0010_0000,
      ST_READ   = 8'b0100_0000,
      ST_EVAL   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      finish;

   assign accept = start && (state_ff == ST_IDLE);
   assign finish = status.hit || status.last;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.capture = start;
            if (accept) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // captured word decides between a store and a probe
            if (status.is_probe) begin
               cmd.calc_coord = 1'b1;
               state_in       = ST_TILE;
            end else begin
               cmd.tile_write = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_COORD: begin
            cmd.calc_coord = 1'b1;
            state_in       = ST_TILE;
         end
         ST_TILE: begin
            cmd.calc_tile = 1'b1;
            state_in      = ST_TERM;
         end
         ST_TERM: begin
            cmd.calc_term = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (finish) begin
               cmd.respond  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/tep_datapath.sv -----
// tep_datapath: request capture, edge geometry, sample walk and tile store ports
// depends on tep_pkg; drives the tep_ram ports

module tep_datapath #(
   parameter int MAP_COLS    = tep_pkg::MAP_COLS_DEF,
   parameter int MAP_ROWS    = tep_pkg::MAP_ROWS_DEF,
   parameter int TILE_PIXELS = tep_pkg::TILE_PIXELS_DEF,
   parameter int ADDR_W      = $clog2(MAP_COLS * MAP_ROWS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tep_pkg::tep_cmd_type        cmd,
   output tep_pkg::tep_status_type     status,
   input  logic                        req_cmd,
   input  logic [tep_pkg::IDX_W-1:0]   req_tile_index,
   input  logic [tep_pkg::VAL_W-1:0]   req_tile_value,
   input  logic [tep_pkg::POSX_W-1:0]  req_pos_x,
   input  logic [tep_pkg::POSY_W-1:0]  req_pos_y,
   input  logic [tep_pkg::OFS8_W-1:0]  req_off_x,
   input  logic [tep_pkg::OFS8_W-1:0]  req_off_y,
   input  logic [tep_pkg::OFS8_W-1:0]  req_size_x,
   input  logic [tep_pkg::OFS8_W-1:0]  req_size_y,
   input  logic [tep_pkg::SIDE_W-1:0]  req_side,
   output logic                        ram_wr_en,
   output logic [ADDR_W-1:0]           ram_wr_addr,
   output logic                        ram_wr_data,
   output logic [ADDR_W-1:0]           ram_rd_addr_in,
   input  logic                        ram_rd_data_in,
   output logic [ADDR_W-1:0]           ram_rd_addr_out,
   input  logic                        ram_rd_data_out,
   output logic [tep_pkg::CODE_W-1:0]  rsp_hit_code
);

   localparam int COORD_W   = tep_pkg::COORD_W;
   localparam int TILE_W    = tep_pkg::TILE_W;
   localparam int LEN_W     = tep_pkg::OFS8_W;
   localparam int LIM_W     = TILE_W + 1;
   localparam int MAP_TILES = MAP_COLS * MAP_ROWS;
   localparam int RECIP     = ((1 << tep_pkg::DIV_SHIFT) + TILE_PIXELS - 1) / TILE_PIXELS;
   localparam int RECIP_W   = tep_pkg::DIV_SHIFT - 1;
   localparam int PROD_W    = COORD_W + RECIP_W;

   // pixel to tile by reciprocal multiply, exact for coordinates below 2**12
   function automatic logic [TILE_W-1:0] to_tile(input logic [COORD_W-1:0] c);
      logic [PROD_W-1:0] p;
      p = PROD_W'(c) * PROD_W'(RECIP);
      return p[tep_pkg::DIV_SHIFT +: TILE_W];
   endfunction

   function automatic logic [COORD_W-1:0] dec_sat(input logic [COORD_W-1:0] v);
      return (v == '0) ? '0 : v - COORD_W'(1);
   endfunction

   // captured request
   logic                       cmd_ff;
   logic [tep_pkg::IDX_W-1:0]  idx_ff;
   logic [tep_pkg::VAL_W-1:0]  val_ff;
   logic [tep_pkg::POSX_W-1:0] pos_x_ff;
   logic [tep_pkg::POSY_W-1:0] pos_y_ff;
   logic [LEN_W-1:0]           off_x_ff;
   logic [LEN_W-1:0]           off_y_ff;
   logic [LEN_W-1:0]           size_x_ff;
   logic [LEN_W-1:0]           size_y_ff;
   logic [tep_pkg::SIDE_W-1:0] side_ff;

   // edge geometry
   logic               horiz_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [COORD_W-1:0] along_base_ff;
   logic [COORD_W-1:0] along_end_ff;
   logic [COORD_W-1:0] perp_in_ff;
   logic [COORD_W-1:0] perp_out_ff;
   logic               horiz_in;
   logic [LEN_W-1:0]   len_in;
   logic [COORD_W-1:0] along_base_in;
   logic [COORD_W-1:0] perp_in_in;
   logic [COORD_W-1:0] perp_out_in;
   logic [COORD_W-1:0] x0;
   logic [COORD_W-1:0] y0;

   // tile numbers
   logic [TILE_W-1:0] start_tile_ff;
   logic [TILE_W-1:0] end_tile_ff;
   logic [TILE_W-1:0] pin_tile_ff;
   logic [TILE_W-1:0] pout_tile_ff;

   // walk state
   logic [ADDR_W-1:0] pin_term_ff;
   logic [ADDR_W-1:0] pout_term_ff;
   logic [ADDR_W-1:0] end_term_ff;
   logic [ADDR_W-1:0] along_term_ff;
   logic [ADDR_W-1:0] along_term_in;
   logic [ADDR_W-1:0] stride;
   logic [TILE_W-1:0] along_tile_ff;
   logic [TILE_W-1:0] along_tile_in;
   logic              pin_ok_ff;
   logic              pout_ok_ff;
   logic [LEN_W-1:0]  ofs_ff;
   logic [LEN_W-1:0]  ofs_in;
   logic [LEN_W:0]    ofs_next;
   logic              along_ok;
   logic [tep_pkg::CODE_W-1:0] code;
   logic [tep_pkg::CODE_W-1:0] code_ff;

   // clear sweep
   logic [ADDR_W-1:0] clr_ff;
   logic              idx_in_map;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_cmd;
         idx_ff    <= req_tile_index;
         val_ff    <= req_tile_value;
         pos_x_ff  <= req_pos_x;
         pos_y_ff  <= req_pos_y;
         off_x_ff  <= req_off_x;
         off_y_ff  <= req_off_y;
         size_x_ff <= req_size_x;
         size_y_ff <= req_size_y;
         side_ff   <= req_side;
      end
   end

   // box corner, then the base coordinate along the edge and the inner and outer ones across it
   always_comb begin
      x0            = COORD_W'(pos_x_ff) + COORD_W'(off_x_ff);
      y0            = COORD_W'(pos_y_ff) + COORD_W'(off_y_ff);
      horiz_in      = (side_ff == tep_pkg::SIDE_BOTTOM) || (side_ff == tep_pkg::SIDE_TOP);
      len_in        = horiz_in ? size_x_ff : size_y_ff;
      along_base_in = horiz_in ? x0 : y0;
      case (side_ff)
         tep_pkg::SIDE_BOTTOM: begin
            perp_in_in  = y0 + COORD_W'(size_y_ff);
            perp_out_in = perp_in_in + COORD_W'(1);
         end
         tep_pkg::SIDE_TOP: begin
            perp_in_in  = y0;
            perp_out_in = dec_sat(y0);
         end
         tep_pkg::SIDE_LEFT: begin
            perp_in_in  = x0;
            perp_out_in = dec_sat(x0);
         end
         tep_pkg::SIDE_RIGHT: begin
            perp_in_in  = x0 + COORD_W'(size_x_ff);
            perp_out_in = perp_in_in + COORD_W'(1);
         end
         default: begin
            perp_in_in  = '0;
            perp_out_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_coord) begin
         horiz_ff      <= horiz_in;
         len_ff        <= len_in;
         along_base_ff <= along_base_in;
         along_end_ff  <= along_base_in + COORD_W'(len_in);
         perp_in_ff    <= perp_in_in;
         perp_out_ff   <= perp_out_in;
      end
      if (cmd.calc_tile) begin
         start_tile_ff <= to_tile(along_base_ff);
         end_tile_ff   <= to_tile(along_end_ff);
         pin_tile_ff   <= to_tile(perp_in_ff);
         pout_tile_ff  <= to_tile(perp_out_ff);
      end
   end

   // horizontal edges step by one column, vertical ones by one row
   assign stride = horiz_ff ? ADDR_W'(1) : ADDR_W'(MAP_COLS);

   assign ofs_next = {1'b0, ofs_ff} + (LEN_W + 1)'(TILE_PIXELS);

   always_comb begin
      if (ofs_next <= {1'b0, len_ff}) begin
         ofs_in        = ofs_next[LEN_W-1:0];
         along_tile_in = along_tile_ff + TILE_W'(1);
         along_term_in = along_term_ff + stride;
      end else begin
         // closing sample sits on the far corner of the edge
         ofs_in        = len_ff;
         along_tile_in = end_tile_ff;
         along_term_in = end_term_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_term) begin
         ofs_ff        <= '0;
         along_tile_ff <= start_tile_ff;
         if (horiz_ff) begin
            pin_term_ff   <= ADDR_W'(pin_tile_ff) * ADDR_W'(MAP_COLS);
            pout_term_ff  <= ADDR_W'(pout_tile_ff) * ADDR_W'(MAP_COLS);
            along_term_ff <= ADDR_W'(start_tile_ff);
            end_term_ff   <= ADDR_W'(end_tile_ff);
            pin_ok_ff     <= {1'b0, pin_tile_ff} < LIM_W'(MAP_ROWS);
            pout_ok_ff    <= {1'b0, pout_tile_ff} < LIM_W'(MAP_ROWS);
         end else begin
            pin_term_ff   <= ADDR_W'(pin_tile_ff);
            pout_term_ff  <= ADDR_W'(pout_tile_ff);
            along_term_ff <= ADDR_W'(start_tile_ff) * ADDR_W'(MAP_COLS);
            end_term_ff   <= ADDR_W'(end_tile_ff) * ADDR_W'(MAP_COLS);
            pin_ok_ff     <= {1'b0, pin_tile_ff} < LIM_W'(MAP_COLS);
            pout_ok_ff    <= {1'b0, pout_tile_ff} < LIM_W'(MAP_COLS);
         end
      end else if (cmd.step) begin
         ofs_ff        <= ofs_in;
         along_tile_ff <= along_tile_in;
         along_term_ff <= along_term_in;
      end
   end

   // addresses wrap harmlessly when a tile lies off the map; the bounds flags mask them
   assign ram_rd_addr_in  = pin_term_ff + along_term_ff;
   assign ram_rd_addr_out = pout_term_ff + along_term_ff;

   assign along_ok = horiz_ff ? ({1'b0, along_tile_ff} < LIM_W'(MAP_COLS))
                              : ({1'b0, along_tile_ff} < LIM_W'(MAP_ROWS));

   assign code[0] = along_ok && pout_ok_ff && ram_rd_data_out;
   assign code[1] = along_ok && pin_ok_ff && ram_rd_data_in;

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         code_ff <= code;
      end
   end

   assign rsp_hit_code = code_ff;

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   assign idx_in_map = 32'(idx_ff) < 32'(MAP_TILES);

   assign ram_wr_en   = cmd.clear_step || (cmd.tile_write && idx_in_map);
   assign ram_wr_addr = cmd.clear_step ? clr_ff : ADDR_W'(idx_ff);
   assign ram_wr_data = cmd.clear_step ? 1'b0 : (val_ff != '0);

   assign status.is_probe   = (cmd_ff == tep_pkg::CMD_PROBE);
   assign status.clear_done = (clr_ff == ADDR_W'(MAP_TILES - 1));
   assign status.hit        = (code != '0);
   assign status.last       = (ofs_ff == len_ff);

endmodule

// ----- hw/rtl/tilemap_edge_probe.sv -----
// tilemap_edge_probe: top level of the tile map collision edge probe
// depends on tep_pkg, tep_ctrl, tep_datapath and tep_ram

// Keeps one solid flag per tile of a MAP_COLS x MAP_ROWS map and probes one
// edge of a hitbox against it. A word is taken when start is high and busy is
// low. A write word (req_cmd 0) stores one flag and returns nothing; busy is
// high for one cycle after it. A probe word (req_cmd 1) returns one result on
// rsp_hit_code, marked by a one-cycle rsp_valid strobe that cannot be held
// off: the receiver must take it in that cycle. A probe keeps busy high while
// three setup steps convert the box into edge coordinates, tile numbers and
// store addresses, and then while the edge samples are walked up to the first
// hit (at most 17 samples with the default 16-pixel tiles and 8-bit box sizes);
// each sample takes one tile-store read on both read ports and one compare.
// The strobe comes in the cycle that busy drops. After reset the tile store is
// cleared one entry per cycle, all MAP_COLS*MAP_ROWS entries (4096 by default),
// and busy stays high until the clearing is done.

module tilemap_edge_probe #(
   parameter int MAP_COLS    = tep_pkg::MAP_COLS_DEF,
   parameter int MAP_ROWS    = tep_pkg::MAP_ROWS_DEF,
   parameter int TILE_PIXELS = tep_pkg::TILE_PIXELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request word
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [tep_pkg::IDX_W-1:0]   req_tile_index,
   input  logic [tep_pkg::VAL_W-1:0]   req_tile_value,
   input  logic [tep_pkg::POSX_W-1:0]  req_pos_x,
   input  logic [tep_pkg::POSY_W-1:0]  req_pos_y,
   input  logic [tep_pkg::OFS8_W-1:0]  req_off_x,
   input  logic [tep_pkg::OFS8_W-1:0]  req_off_y,
   input  logic [tep_pkg::OFS8_W-1:0]  req_size_x,
   input  logic [tep_pkg::OFS8_W-1:0]  req_size_y,
   input  logic [tep_pkg::SIDE_W-1:0]  req_side,
   // result word
   output logic                        rsp_valid,
   output logic [tep_pkg::CODE_W-1:0]  rsp_hit_code
);

   localparam int MAP_TILES = MAP_COLS * MAP_ROWS;
   localparam int ADDR_W    = $clog2(MAP_TILES);

   tep_pkg::tep_cmd_type    cmd;
   tep_pkg::tep_status_type status;

   // tile store ports
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr_in;
   logic              ram_rd_data_in;
   logic [ADDR_W-1:0] ram_rd_addr_out;
   logic              ram_rd_data_out;

   // sequencing: clear sweep, write, setup and the read/compare walk
   tep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // geometry, sample walk and hit code
   tep_datapath #(
      .MAP_COLS    (MAP_COLS),
      .MAP_ROWS    (MAP_ROWS),
      .TILE_PIXELS (TILE_PIXELS),
      .ADDR_W      (ADDR_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_tile_index  (req_tile_index),
      .req_tile_value  (req_tile_value),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_off_x       (req_off_x),
      .req_off_y       (req_off_y),
      .req_size_x      (req_size_x),
      .req_size_y      (req_size_y),
      .req_side        (req_side),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr_in  (ram_rd_addr_in),
      .ram_rd_data_in  (ram_rd_data_in),
      .ram_rd_addr_out (ram_rd_addr_out),
      .ram_rd_data_out (ram_rd_data_out),
      .rsp_hit_code    (rsp_hit_code)
   );

   // solid flags: port a reads the tile inside the edge, port b the one outside
   tep_ram #(
      .WIDTH  (1),
      .DEPTH  (MAP_TILES),
      .ADDR_W (ADDR_W)
   ) u_tile_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_in),
      .rd_data_a (ram_rd_data_in),
      .rd_addr_b (ram_rd_addr_out),
      .rd_data_b (ram_rd_data_out)
   );

endmodule

// ----- sim/tep_probe_checker.sv -----
// tep_probe_checker: watches the request and result channels of tilemap_edge_probe,
// keeps its own copy of the tile flags and checks every probe hit code in order
// depends on tep_pkg

module tep_probe_checker
   import tep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_cmd,
   input  logic [IDX_W-1:0]   req_tile_index,
   input  logic [VAL_W-1:0]   req_tile_value,
   input  logic [POSX_W-1:0]  req_pos_x,
   input  logic [POSY_W-1:0]  req_pos_y,
   input  logic [OFS8_W-1:0]  req_off_x,
   input  logic [OFS8_W-1:0]  req_off_y,
   input  logic [OFS8_W-1:0]  req_size_x,
   input  logic [OFS8_W-1:0]  req_size_y,
   input  logic [SIDE_W-1:0]  req_side,
   input  logic               rsp_valid,
   input  logic [CODE_W-1:0]  rsp_hit_code,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS    = MAP_COLS_DEF;
   localparam int ROWS    = MAP_ROWS_DEF;
   localparam int TILE_PX = TILE_PIXELS_DEF;
   localparam int FLAG_AW = $clog2(COLS*ROWS);

   bit                tile_flags [COLS*ROWS];
   logic [CODE_W-1:0] expected_codes [$];
   int                mismatches;

   initial begin
      mismatches = 0;
   end

   // signed division truncates toward zero, so pixel -1 lands in tile 0
   function automatic bit solid_tile(int x, int y);
      int col;
      int row;
      col = x / TILE_PX;
      row = y / TILE_PX;
      if (col < 0 || row < 0 || col >= COLS || row >= ROWS)
         return 1'b0;
      return tile_flags[FLAG_AW'(row*COLS + col)];
   endfunction

   function automatic logic [CODE_W-1:0] edge_hit_code(int x0, int y0, int sx, int sy,
                                                       logic [SIDE_W-1:0] sd);
      int                span;
      int                ofs;
      bit                inner;
      bit                outer;
      span = (sd == SIDE_BOTTOM || sd == SIDE_TOP) ? sx : sy;
      ofs  = 0;
      while (1) begin
         case (sd)
            SIDE_BOTTOM: begin
               inner = solid_tile(x0 + ofs, y0 + sy);
               outer = solid_tile(x0 + ofs, y0 + sy + 1);
            end
            SIDE_TOP: begin
               inner = solid_tile(x0 + ofs, y0);
               outer = solid_tile(x0 + ofs, y0 - 1);
            end
            SIDE_LEFT: begin
               inner = solid_tile(x0, y0 + ofs);
               outer = solid_tile(x0 - 1, y0 + ofs);
            end
            default: begin
               inner = solid_tile(x0 + sx, y0 + ofs);
               outer = solid_tile(x0 + sx + 1, y0 + ofs);
            end
         endcase
         if (inner || outer)
            return {inner, outer};
         if (ofs == span)
            return '0;
         // whole tiles while they fit, then one last sample at the far corner
         ofs = (ofs + TILE_PX <= span) ? ofs + TILE_PX : span;
      end
   endfunction

   always @(posedge clock) begin
      logic [CODE_W-1:0] want;
      if (reset) begin
         tile_flags = '{default: 1'b0};
         expected_codes.delete();
      end else begin
         // result first: a new word may be taken in the cycle the strobe shows
         if (rsp_valid) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected hit code, expected none, got %0d",
                        $time, rsp_hit_code);
               mismatches++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_hit_code !== want) begin
                  $display("%0t: hit code mismatch, expected %0d, got %0d",
                           $time, want, rsp_hit_code);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            if (req_cmd == CMD_WRITE) begin
               if (int'(req_tile_index) < COLS*ROWS)
                  tile_flags[req_tile_index] = (req_tile_value != '0);
            end else begin
               expected_codes.push_back(edge_hit_code(int'(req_pos_x) + int'(req_off_x),
                                                      int'(req_pos_y) + int'(req_off_y),
                                                      int'(req_size_x), int'(req_size_y),
                                                      req_side));
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_codes.size();
   end

endmodule

// ----- sim/tb_tilemap_edge_probe.sv -----
// tb_tilemap_edge_probe: stimulus and verdict for the tile map edge probe
// depends on tep_pkg, tilemap_edge_probe and the checker in tep_probe_checker.sv

module tb_tilemap_edge_probe;
   timeunit 1ns;
   timeprecision 1ps;
   import tep_pkg::*;

   localparam int ITEMS   = 2000;
   localparam int COLS    = MAP_COLS_DEF;
   localparam int ROWS    = MAP_ROWS_DEF;
   localparam int TILE_PX = TILE_PIXELS_DEF;

   // one request word as the testbench builds it
   typedef struct {
      logic              cmd;
      logic [IDX_W-1:0]  tile_index;
      logic [VAL_W-1:0]  tile_value;
      logic [POSX_W-1:0] pos_x;
      logic [POSY_W-1:0] pos_y;
      logic [OFS8_W-1:0] off_x;
      logic [OFS8_W-1:0] off_y;
      logic [OFS8_W-1:0] size_x;
      logic [OFS8_W-1:0] size_y;
      logic [SIDE_W-1:0] side;
   } edge_word_type;

   logic              clock;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   logic              req_cmd        = CMD_WRITE;
   logic [IDX_W-1:0]  req_tile_index = '0;
   logic [VAL_W-1:0]  req_tile_value = '0;
   logic [POSX_W-1:0] req_pos_x      = '0;
   logic [POSY_W-1:0] req_pos_y      = '0;
   logic [OFS8_W-1:0] req_off_x      = '0;
   logic [OFS8_W-1:0] req_off_y      = '0;
   logic [OFS8_W-1:0] req_size_x     = '0;
   logic [OFS8_W-1:0] req_size_y     = '0;
   logic [SIDE_W-1:0] req_side       = SIDE_BOTTOM;
   logic              rsp_valid;
   logic [CODE_W-1:0] rsp_hit_code;

   int fail_count;
   int pending;
   int items_sent = 0;
   bit idle_on    = 1'b1;

   tilemap_edge_probe DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_tile_index (req_tile_index),
      .req_tile_value (req_tile_value),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_off_x      (req_off_x),
      .req_off_y      (req_off_y),
      .req_size_x     (req_size_x),
      .req_size_y     (req_size_y),
      .req_side       (req_side),
      .rsp_valid      (rsp_valid),
      .rsp_hit_code   (rsp_hit_code)
   );

   // predicts and compares; hands back the mismatch count and the open probes
   tep_probe_checker u_probe_chk (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_tile_index (req_tile_index),
      .req_tile_value (req_tile_value),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_off_x      (req_off_x),
      .req_off_y      (req_off_y),
      .req_size_x     (req_size_x),
      .req_size_y     (req_size_y),
      .req_side       (req_side),
      .rsp_valid      (rsp_valid),
      .rsp_hit_code   (rsp_hit_code),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop; the slowest correct run (clearing pass plus 2000 full walks
   // with the longest gaps) stays near 2.2 ms
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // every field random, so bits that a word does not use still toggle
   function automatic edge_word_type random_word();
      edge_word_type w;
      w.cmd        = 1'($urandom_range(0, 1));
      w.tile_index = IDX_W'($urandom_range(0, 4095));
      w.tile_value = VAL_W'($urandom_range(0, 255));
      w.pos_x      = POSX_W'($urandom_range(0, 2047));
      w.pos_y      = POSY_W'($urandom_range(0, 511));
      w.off_x      = OFS8_W'($urandom_range(0, 255));
      w.off_y      = OFS8_W'($urandom_range(0, 255));
      w.size_x     = OFS8_W'($urandom_range(0, 255));
      w.size_y     = OFS8_W'($urandom_range(0, 255));
      w.side       = SIDE_W'($urandom_range(0, 3));
      return w;
   endfunction

   // mostly short boxes, now and then a long edge walk
   function automatic logic [OFS8_W-1:0] pick_size();
      return ($urandom_range(0, 3) == 0) ? OFS8_W'($urandom_range(0, 255))
                                         : OFS8_W'($urandom_range(0, 47));
   endfunction

   // drive one word and hold it until the block takes it; start is only
   // lowered for an idle burst, never dropped and raised in the same step
   task automatic send_word(input edge_word_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= w.cmd;
      req_tile_index <= w.tile_index;
      req_tile_value <= w.tile_value;
      req_pos_x      <= w.pos_x;
      req_pos_y      <= w.pos_y;
      req_off_x      <= w.off_x;
      req_off_y      <= w.off_y;
      req_size_x     <= w.size_x;
      req_size_y     <= w.size_y;
      req_side       <= w.side;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_tile(input int idx, input int val);
      edge_word_type w;
      w            = random_word();
      w.cmd        = CMD_WRITE;
      w.tile_index = IDX_W'(idx);
      w.tile_value = VAL_W'(val);
      send_word(w);
   endtask

   task automatic probe_edge(input int px, input int py, input int ox, input int oy,
                             input int sx, input int sy, input logic [SIDE_W-1:0] sd);
      edge_word_type w;
      w        = random_word();
      w.cmd    = CMD_PROBE;
      w.pos_x  = POSX_W'(px);
      w.pos_y  = POSY_W'(py);
      w.off_x  = OFS8_W'(ox);
      w.off_y  = OFS8_W'(oy);
      w.size_x = OFS8_W'(sx);
      w.size_y = OFS8_W'(sy);
      w.side   = sd;
      send_word(w);
   endtask

   // a random box (pos_x kept at 1900 or below), a few tiles planted on or next to the probed edge,
   // then the probe itself; this is what gets hits at every code and sample
   task automatic edge_sequence();
      edge_word_type pw;
      edge_word_type ww;
      int         x0;
      int         y0;
      int         span;
      int         a;
      int         px;
      int         py;
      int         nplant;
      pw        = random_word();
      pw.cmd    = CMD_PROBE;
      pw.pos_x  = POSX_W'($urandom_range(0, 1900));
      pw.size_x = pick_size();
      pw.size_y = pick_size();
      x0        = int'(pw.pos_x) + int'(pw.off_x);
      y0        = int'(pw.pos_y) + int'(pw.off_y);
      span      = (pw.side == SIDE_BOTTOM || pw.side == SIDE_TOP) ? int'(pw.size_x)
                                                                  : int'(pw.size_y);
      nplant    = $urandom_range(1, 4);
      repeat (nplant) begin
         a = $urandom_range(0, span);
         // inside pixel or the one just past the edge
         case (pw.side)
            SIDE_BOTTOM: begin
               px = x0 + a;
               py = y0 + int'(pw.size_y) + int'($urandom_range(0, 1));
            end
            SIDE_TOP: begin
               px = x0 + a;
               py = y0 - int'($urandom_range(0, 1));
            end
            SIDE_LEFT: begin
               px = x0 - int'($urandom_range(0, 1));
               py = y0 + a;
            end
            default: begin
               px = x0 + int'(pw.size_x) + int'($urandom_range(0, 1));
               py = y0 + a;
            end
         endcase
         ww     = random_word();
         ww.cmd = CMD_WRITE;
         if (px >= 0 && py >= 0 && px / TILE_PX < COLS && py / TILE_PX < ROWS)
            ww.tile_index = IDX_W'((py / TILE_PX) * COLS + px / TILE_PX);
         ww.tile_value = ($urandom_range(0, 4) == 0) ? '0 : VAL_W'($urandom_range(1, 255));
         send_word(ww);
      end
      send_word(pw);
   endtask

   // sender holds off until every open probe has answered; pending is a registered
   // copy of the checker's queue size, so look only after the next edge
   task automatic drain_probes();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      edge_word_type w;
      int         pick;
      int         next_toggle;
      int         waited;
      bit         drained;
      next_toggle = 150;
      drained     = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // the clearing pass keeps busy high; the first word simply waits it out

      // directed: corner tiles, pixel -1 on top and left, inside-only,
      // outside-only and both, hit on the last sample, off-map boxes,
      // zero and full sizes, empty full-length walks on every side
      write_tile(0, 255);
      write_tile(COLS*ROWS - 1, 1);
      write_tile(COLS + 1, 8'h80);
      write_tile(5*COLS + 20, 8'h01);
      probe_edge(0, 0, 0, 0, 0, 0, SIDE_TOP);
      probe_edge(0, 0, 0, 0, 0, 0, SIDE_LEFT);
      probe_edge(0, 0, 0, 0, 0, 15, SIDE_BOTTOM);
      probe_edge(0, 16, 0, 0, 15, 0, SIDE_RIGHT);
      probe_edge(2032, 496, 0, 0, 0, 0, SIDE_BOTTOM);
      probe_edge(2047, 0, 255, 0, 255, 255, SIDE_RIGHT);
      probe_edge(0, 511, 0, 255, 255, 255, SIDE_BOTTOM);
      probe_edge(0, 16, 0, 0, 255, 0, SIDE_TOP);
      probe_edge(70, 0, 0, 0, 250, 80, SIDE_BOTTOM);
      write_tile(0, 0);
      write_tile(COLS + 1, 0);
      probe_edge(0, 0, 0, 0, 255, 255, SIDE_BOTTOM);
      probe_edge(0, 0, 0, 0, 255, 255, SIDE_TOP);
      probe_edge(0, 0, 0, 0, 255, 255, SIDE_LEFT);
      probe_edge(0, 0, 0, 0, 255, 255, SIDE_RIGHT);
      probe_edge(2047, 511, 255, 255, 255, 255, SIDE_RIGHT);
      write_tile(COLS*ROWS - 1, 0);

      // random part: planted edge sequences, stray writes and stray probes
      while (items_sent < ITEMS) begin
         if (items_sent >= next_toggle) begin
            // stretches with and without idle bursts
            idle_on     = ($urandom_range(0, 2) != 0);
            next_toggle += 150;
         end
         if (items_sent >= ITEMS - 250)
            idle_on = 1'b0;
         if (!drained && items_sent >= ITEMS / 2) begin
            drain_probes();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            edge_sequence();
         end else if (pick < 70) begin
            w     = random_word();
            w.cmd = CMD_WRITE;
            if ($urandom_range(0, 2) == 0)
               w.tile_value = '0;
            send_word(w);
         end else begin
            w     = random_word();
            w.cmd = CMD_PROBE;
            send_word(w);
         end
      end

      // wait for the last results, then a little past the longest probe
      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (pending != 0)
         $display("%0t: %0d probe results never arrived, expected %0d more, got none",
                  $time, pending, pending);
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
